>>> rtl/b64c_pkg.sv
// Base64 codec package: shared types, character constants and alphabet functions.
// Used by b64c_step, base64_codec, b64c_checker and tb_base64_codec; depends on nothing.
package b64c_pkg;

	// results one item can cause at most
	localparam int unsigned MAX_RES = 4;
	localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
	localparam int unsigned RES_IDX_W = $clog2(MAX_RES);

	// mode register values
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// ASCII characters with a special meaning
	localparam logic [7:0] CHAR_PAD   = 8'h3D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	// one result item
	typedef struct packed {
		logic [7:0] data;
		logic       has_data;
		logic       last;
		logic       bad_char;
	} b64c_res_t;

	// all results caused by one input item
	typedef b64c_res_t [MAX_RES-1:0] b64c_res_vec_t;

	// collected bytes or sextets, newest in the low bits
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  count;
		logic        err;
	} b64c_state_t;

	localparam b64c_state_t STATE_CLEAR = '0;
	localparam b64c_res_t   RES_NONE    = '0;

	// sextet to alphabet character
	function automatic logic [7:0] b64c_char(input logic [5:0] s);
		logic [7:0] w;
		logic [7:0] r;
		w = {2'b00, s};
		if (s < 6'd26) begin
			r = w + 8'h41;
		end else if (s < 6'd52) begin
			r = w + 8'h47;
		end else if (s < 6'd62) begin
			r = w - 8'd4;
		end else if (s == 6'd62) begin
			r = CHAR_PLUS;
		end else begin
			r = CHAR_SLASH;
		end
		return r;
	endfunction

	// alphabet character to sextet, top bit set for a character outside the alphabet
	function automatic logic [6:0] b64c_sextet(input logic [7:0] c);
		logic [6:0] r;
		r = {1'b1, 6'd0};
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = {1'b0, 6'(c - 8'h41)};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			r = {1'b0, 6'(c - 8'h47)};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 6'(c + 8'd4)};
		end else if (c == CHAR_PLUS) begin
			r = {1'b0, 6'd62};
		end else if (c == CHAR_SLASH) begin
			r = {1'b0, 6'd63};
		end
		return r;
	endfunction

endpackage

>>> rtl/b64c_step.sv
// Base64 codec step logic: next state and the result list for one input item.
// Purely combinational; depends on b64c_pkg.
module b64c_step (
	input  logic                       mode,
	input  b64c_pkg::b64c_state_t      state,
	input  logic [7:0]                 data_in,
	input  logic                       end_of_string,
	output b64c_pkg::b64c_state_t      state_next,
	output b64c_pkg::b64c_res_vec_t    res,
	output logic [b64c_pkg::RES_CNT_W-1:0] res_cnt
);
	import b64c_pkg::*;

	logic [1:0]  ecnt;
	logic [23:0] ebits;
	logic [23:0] etail;
	logic        skip;
	logic [6:0]  sx;
	logic [23:0] dbits;
	logic [2:0]  dcnt;
	b64c_state_t w;

	always_comb begin
		res        = '{default: RES_NONE};
		res_cnt    = '0;
		state_next = state;
		ecnt       = 2'(state.count + 2'd1);
		ebits      = {state.bits[15:0], data_in};
		etail      = (ecnt == 2'd1) ? {ebits[7:0], 16'd0} : {ebits[15:0], 8'd0};
		skip       = (data_in == CHAR_PAD) || (data_in == CHAR_LF) ||
		             (data_in == CHAR_CR) || (data_in == CHAR_SPACE);
		sx         = b64c_sextet(data_in);
		dbits      = {state.bits[17:0], sx[5:0]};
		dcnt       = {1'b0, state.count} + 3'd1;
		w          = state;

		if (mode == MODE_ENCODE) begin
			// full group of three bytes gives four characters
			if (ecnt == 2'd3) begin
				res[0] = '{data: b64c_char(ebits[23:18]), has_data: 1'b1, last: 1'b0,
				           bad_char: 1'b0};
				res[1] = '{data: b64c_char(ebits[17:12]), has_data: 1'b1, last: 1'b0,
				           bad_char: 1'b0};
				res[2] = '{data: b64c_char(ebits[11:6]), has_data: 1'b1, last: 1'b0,
				           bad_char: 1'b0};
				res[3] = '{data: b64c_char(ebits[5:0]), has_data: 1'b1,
				           last: end_of_string, bad_char: 1'b0};
				res_cnt = RES_CNT_W'(4);
				state_next = STATE_CLEAR;
			end else if (end_of_string) begin
				// partial group flushed with padding
				res[0] = '{data: b64c_char(etail[23:18]), has_data: 1'b1, last: 1'b0,
				           bad_char: 1'b0};
				res[1] = '{data: b64c_char(etail[17:12]), has_data: 1'b1, last: 1'b0,
				           bad_char: 1'b0};
				res[2] = '{data: (ecnt == 2'd2) ? b64c_char(etail[11:6]) : CHAR_PAD,
				           has_data: 1'b1, last: 1'b0, bad_char: 1'b0};
				res[3] = '{data: CHAR_PAD, has_data: 1'b1, last: 1'b1, bad_char: 1'b0};
				res_cnt = RES_CNT_W'(4);
			end else begin
				state_next = '{bits: ebits, count: ecnt, err: 1'b0};
			end
			if (end_of_string) begin
				state_next = STATE_CLEAR;
			end
		end else begin
			// collect one sextet, four of them give three bytes
			if (!state.err && !skip) begin
				if (sx[6]) begin
					w.err = 1'b1;
				end else if (dcnt == 3'd4) begin
					res[0] = '{data: dbits[23:16], has_data: 1'b1, last: 1'b0,
					           bad_char: 1'b0};
					res[1] = '{data: dbits[15:8], has_data: 1'b1, last: 1'b0,
					           bad_char: 1'b0};
					res[2] = '{data: dbits[7:0], has_data: 1'b1, last: 1'b0,
					           bad_char: 1'b0};
					res_cnt = RES_CNT_W'(3);
					w.bits  = '0;
					w.count = '0;
				end else begin
					w.bits  = dbits;
					w.count = dcnt[1:0];
				end
			end
			state_next = w;

			// end of string: leftover sextets, error marker, bare end marker or last flag
			if (end_of_string) begin
				if (w.err) begin
					res[0]  = '{data: 8'd0, has_data: 1'b0, last: 1'b1, bad_char: 1'b1};
					res_cnt = RES_CNT_W'(1);
				end else if (w.count == 2'd2) begin
					res[0]  = '{data: {w.bits[11:6], w.bits[5:4]}, has_data: 1'b1,
					            last: 1'b1, bad_char: 1'b0};
					res_cnt = RES_CNT_W'(1);
				end else if (w.count == 2'd3) begin
					res[0]  = '{data: {w.bits[17:12], w.bits[11:10]}, has_data: 1'b1,
					            last: 1'b0, bad_char: 1'b0};
					res[1]  = '{data: {w.bits[9:6], w.bits[5:2]}, has_data: 1'b1,
					            last: 1'b1, bad_char: 1'b0};
					res_cnt = RES_CNT_W'(2);
				end else if (res_cnt == '0) begin
					res[0]  = '{data: 8'd0, has_data: 1'b0, last: 1'b1, bad_char: 1'b0};
					res_cnt = RES_CNT_W'(1);
				end else begin
					res[2].last = 1'b1;
				end
				state_next = STATE_CLEAR;
			end
		end
	end

endmodule

>>> rtl/base64_codec.sv
// Streaming Base64 encoder and decoder, top level.
// Depends on b64c_pkg and b64c_step.
//
// Input channel (in_valid/in_ready): one item per handshake, data_in plus
// end_of_string. In encode mode data_in is a raw byte, in decode mode an ASCII
// character. Output channel (out_valid/out_ready): one result item per
// handshake with data_out, has_data, last and bad_char.
// cfg_wr_en/cfg_wr_data write the mode bit (0 encode, 1 decode);
// a write clears the collected bytes or sextets and the error flag.
// The first result of an item is offered in the cycle after the item is
// accepted. The results of one item sit in a four-entry result register and
// leave one per cycle while the receiver is ready. In encode mode the byte
// that completes a group brings four results, in decode mode a character
// that completes a group three. A new item is taken in the cycle its
// predecessor's last result leaves; an item causing no result does not hold
// up the next one.
// Reset: mode is encode and all collected state is empty. A stalled receiver
// holds the current result; the input stalls while results of the previous
// item remain, unless the only one left is being taken in that cycle.
module base64_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_in,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_out,
	output logic       has_data,
	output logic       last,
	output logic       bad_char
);
	import b64c_pkg::*;

	logic                  mode_q;
	b64c_state_t           state_q;
	b64c_state_t           state_next;
	b64c_res_vec_t         res_new;
	logic [RES_CNT_W-1:0]  res_cnt_new;
	b64c_res_vec_t         res_s1;
	logic [RES_CNT_W-1:0]  rem_q;
	logic [RES_IDX_W-1:0]  idx_q;
	logic                  in_fire;
	logic                  out_fire;
	b64c_res_t             res_cur;

	// per-item work
	b64c_step u_step (
		.mode          (mode_q),
		.state         (state_q),
		.data_in       (data_in),
		.end_of_string (end_of_string),
		.state_next    (state_next),
		.res           (res_new),
		.res_cnt       (res_cnt_new)
	);

	// handshakes
	assign out_valid = (rem_q != '0);
	assign out_fire  = out_valid && out_ready;
	assign in_ready  = (rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && out_ready);
	assign in_fire   = in_valid && in_ready;

	// current result
	assign res_cur  = res_s1[idx_q];
	assign data_out = res_cur.data;
	assign has_data = res_cur.has_data;
	assign last     = res_cur.last;
	assign bad_char = res_cur.bad_char;

	// mode register and collected state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_ENCODE;
			state_q <= STATE_CLEAR;
		end else if (cfg_wr_en) begin
			mode_q  <= cfg_wr_data;
			state_q <= STATE_CLEAR;
		end else if (in_fire) begin
			state_q <= state_next;
		end
	end

	// result register drain counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (in_fire) begin
			rem_q <= res_cnt_new;
			idx_q <= '0;
		end else if (out_fire) begin
			rem_q <= rem_q - RES_CNT_W'(1);
			idx_q <= idx_q + RES_IDX_W'(1);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1 <= res_new;
		end
	end

endmodule

>>> test/b64c_checker.sv
// Checker for the Base64 codec: follows both channels and the mode write port,
// predicts every result item and compares it field by field as it leaves.
// Depends on b64c_pkg for the result type, mode values and character constants.
module b64c_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_in,
	input  logic       end_of_string,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] data_out,
	input  logic       has_data,
	input  logic       last,
	input  logic       bad_char,
	output int         mismatches,
	output int         results_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import b64c_pkg::*;

	// predicted codec state
	logic        mode_q    = MODE_ENCODE;
	logic [23:0] pend_bits = '0;
	logic [1:0]  pend_cnt  = '0;
	logic        err_seen  = 1'b0;

	// predicted result items still to leave the block, oldest first
	b64c_res_t   out_due [$];
	int          out_seen  = 0;

	// sextet to its alphabet character
	function automatic logic [7:0] sextet_char(input logic [5:0] s);
		if (s < 6'd26)
			return "A" + {2'b00, s};
		if (s < 6'd52)
			return "a" + {2'b00, s} - 8'd26;
		if (s < 6'd62)
			return "0" + {2'b00, s} - 8'd52;
		return (s == 6'd62) ? CHAR_PLUS : CHAR_SLASH;
	endfunction

	// alphabet character to its sextet, -1 outside the alphabet
	function automatic int char_sextet(input logic [7:0] c);
		if (c >= "A" && c <= "Z")
			return c - "A";
		if (c >= "a" && c <= "z")
			return c - "a" + 26;
		if (c >= "0" && c <= "9")
			return c - "0" + 52;
		if (c == CHAR_PLUS)
			return 62;
		if (c == CHAR_SLASH)
			return 63;
		return -1;
	endfunction

	function automatic b64c_res_t make_res(input logic [7:0] d, input logic has,
			input logic fin, input logic bad);
		b64c_res_t r;
		r.data     = d;
		r.has_data = has;
		r.last     = fin;
		r.bad_char = bad;
		return r;
	endfunction

	function automatic void clear_codec();
		pend_bits = '0;
		pend_cnt  = '0;
		err_seen  = 1'b0;
	endfunction

	// one accepted item: update the predicted state, queue its results
	function automatic void step_codec(input logic [7:0] d, input logic eos);
		b64c_res_t   got [$];
		logic [23:0] bits;
		logic [23:0] t;
		logic [5:0]  s1;
		int          cnt;
		int          s;
		if (mode_q == MODE_ENCODE) begin
			cnt  = pend_cnt + 1;
			bits = {pend_bits[15:0], d};
			if (cnt == 3) begin
				got = {got, make_res(sextet_char(bits[23:18]), 1'b1, 1'b0, 1'b0)};
				got = {got, make_res(sextet_char(bits[17:12]), 1'b1, 1'b0, 1'b0)};
				got = {got, make_res(sextet_char(bits[11:6]), 1'b1, 1'b0, 1'b0)};
				got = {got, make_res(sextet_char(bits[5:0]), 1'b1, 1'b0, 1'b0)};
				cnt  = 0;
				bits = '0;
			end else if (eos) begin
				// partial group: shift to the top, pad with '='
				t = bits << (8 * (3 - cnt));
				got = {got, make_res(sextet_char(t[23:18]), 1'b1, 1'b0, 1'b0)};
				got = {got, make_res(sextet_char(t[17:12]), 1'b1, 1'b0, 1'b0)};
				got = {got, make_res((cnt == 2) ? sextet_char(t[11:6]) : CHAR_PAD,
					1'b1, 1'b0, 1'b0)};
				got = {got, make_res(CHAR_PAD, 1'b1, 1'b0, 1'b0)};
			end
			pend_bits = bits;
			pend_cnt  = cnt[1:0];
		end else begin
			// pad and whitespace never reach the sextet store
			if (!err_seen && d != CHAR_PAD && d != CHAR_CR && d != CHAR_LF
					&& d != CHAR_SPACE) begin
				s = char_sextet(d);
				if (s < 0) begin
					err_seen = 1'b1;
				end else begin
					bits = {pend_bits[17:0], s[5:0]};
					cnt  = pend_cnt + 1;
					if (cnt == 4) begin
						got = {got, make_res(bits[23:16], 1'b1, 1'b0, 1'b0)};
						got = {got, make_res(bits[15:8], 1'b1, 1'b0, 1'b0)};
						got = {got, make_res(bits[7:0], 1'b1, 1'b0, 1'b0)};
						bits = '0;
						cnt  = 0;
					end
					pend_bits = bits;
					pend_cnt  = cnt[1:0];
				end
			end
			// leftover sextets at the end of a clean string
			if (eos && !err_seen) begin
				s1 = pend_bits[11:6];
				if (pend_cnt == 2'd2) begin
					got = {got, make_res({pend_bits[11:6], pend_bits[5:4]},
						1'b1, 1'b0, 1'b0)};
				end else if (pend_cnt == 2'd3) begin
					got = {got, make_res({pend_bits[17:12], s1[5:4]}, 1'b1, 1'b0, 1'b0)};
					got = {got, make_res({s1[3:0], pend_bits[5:2]}, 1'b1, 1'b0, 1'b0)};
				end
			end
		end
		// end of string: mark the final result or add an error marker or a bare end marker
		if (eos) begin
			if (err_seen)
				got = {got, make_res(8'h00, 1'b0, 1'b1, 1'b1)};
			else if (got.size() == 0)
				got = {got, make_res(8'h00, 1'b0, 1'b1, 1'b0)};
			else
				got[got.size() - 1].last = 1'b1;
			clear_codec();
		end
		out_due = {out_due, got};
	endfunction

	// one line per mismatch
	task automatic report(input string what);
		$display("%0t ns: %s", $realtime, what);
		mismatches = mismatches + 1;
	endtask

	// leaving result item against the oldest prediction
	task automatic check_result();
		b64c_res_t want;
		if (out_due.size() == 0) begin
			report($sformatf("result %0d with nothing due: data_out %h has_data %b last %b",
				out_seen, data_out, has_data, last));
		end else begin
			want = out_due.pop_front();
			if (data_out !== want.data)
				report($sformatf("result %0d data_out %h, predicted %h",
					out_seen, data_out, want.data));
			if (has_data !== want.has_data)
				report($sformatf("result %0d has_data %b, predicted %b",
					out_seen, has_data, want.has_data));
			if (last !== want.last)
				report($sformatf("result %0d last %b, predicted %b",
					out_seen, last, want.last));
			if (bad_char !== want.bad_char)
				report($sformatf("result %0d bad_char %b, predicted %b",
					out_seen, bad_char, want.bad_char));
		end
		out_seen = out_seen + 1;
	endtask

	// channel monitor, results first since they belong to older items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q = MODE_ENCODE;
			clear_codec();
			out_due.delete();
			mismatches = 0;
			results_due <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_wr_en) begin
				mode_q = cfg_wr_data;
				clear_codec();
			end
			if (in_valid && in_ready)
				step_codec(data_in, end_of_string);
			results_due <= out_due.size();
		end
	end

endmodule

>>> test/tb_base64_codec.sv
// Testbench top for the Base64 codec: clock, reset, mode writes, byte and
// character strings with bursty input and a stalling receiver, final verdict.
// Depends on b64c_pkg, base64_codec and b64c_checker.
module tb_base64_codec;
	timeunit 1ns;
	timeprecision 1ps;
	import b64c_pkg::*;

	localparam int ITEM_TARGET  = 180;
	localparam int PHASE_ITEMS  = 30;
	localparam int LIMIT_CYCLES = 300000;

	typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SLOW} rx_style_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_wr_en;
	logic       cfg_wr_data;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_in;
	logic       end_of_string;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_out;
	logic       has_data;
	logic       last;
	logic       bad_char;
	int         mismatches;
	int         results_due;

	logic [7:0] text [$];
	int         burst_left = 0;
	int         cycles = 0;
	rx_style_t  rx_style = RX_FREE;
	int         rx_left = 0;
	logic [7:0] fillers [4] = '{CHAR_PAD, CHAR_CR, CHAR_LF, CHAR_SPACE};

	base64_codec u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_in       (data_in),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_out      (data_out),
		.has_data      (has_data),
		.last          (last),
		.bad_char      (bad_char)
	);

	b64c_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_in       (data_in),
		.end_of_string (end_of_string),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.data_out      (data_out),
		.has_data      (has_data),
		.last          (last),
		.bad_char      (bad_char),
		.mismatches    (mismatches),
		.results_due   (results_due)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// receiver: switches between free running, coin toss and mostly stalled
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 2));
			rx_left  <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_style)
		RX_FREE: out_ready <= 1'b1;
		RX_COIN: out_ready <= 1'($urandom_range(0, 1));
		default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("FAIL");
			$finish;
		end
	end

	// offer one item; the sender may idle between bursts of random length
	task automatic put_item(input logic [7:0] d, input logic eos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left = burst_left - 1;
		in_valid      <= 1'b1;
		data_in       <= d;
		end_of_string <= eos;
		do @(posedge clk); while (!in_ready);
	endtask

	// send the current text, marking its final item when closed
	task automatic send_text(input logic close);
		foreach (text[i])
			put_item(text[i], close && (i == text.size() - 1));
	endtask

	// stop sending until every predicted result has left
	task automatic wait_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (results_due != 0);
	endtask

	// mode write while idle; items with no result may still be in flight
	task automatic set_mode(input logic m);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// random byte string, extremes favored
	task automatic make_bytes();
		int len;
		int r;
		len = $urandom_range(1, 10);
		text.delete();
		repeat (len) begin
			r = $urandom_range(0, 9);
			text = {text, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(0, 255))};
		end
	endtask

	// mostly alphabet characters with some padding and whitespace;
	// a noisy string also carries arbitrary characters
	task automatic make_chars();
		int   len;
		int   r;
		logic noisy;
		noisy = ($urandom_range(0, 4) == 0);
		len   = $urandom_range(1, 14);
		text.delete();
		repeat (len) begin
			r = $urandom_range(0, 19);
			if (noisy && r < 2)
				text = {text, 8'($urandom_range(0, 255))};
			else if (r < 4)
				text = {text, fillers[$urandom_range(0, 3)]};
			else
				text = {text, b64c_char(6'($urandom_range(0, 63)))};
		end
	endtask

	initial begin
		int   sent;
		int   phase_end;
		int   phase;
		logic m;
		logic close;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = 1'b0;
		in_valid      = 1'b0;
		data_in       = 8'h00;
		end_of_string = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode: one and two byte tails, a full group, a string cut by a mode write
		set_mode(MODE_ENCODE);
		text = '{8'h00};
		send_text(1'b1);
		text = '{8'hFF, 8'hFF};
		send_text(1'b1);
		text = '{8'h00, 8'hFF, 8'h80};
		send_text(1'b1);
		text = '{8'h12};
		send_text(1'b0);

		// decode: full group, padding, whitespace with + and /, bad character,
		// a lone sextet, then a string cut by rewriting the same mode
		set_mode(MODE_DECODE);
		text = '{"T", "W", "F", "u"};
		send_text(1'b1);
		text = '{"Q", "Q", CHAR_PAD, CHAR_PAD};
		send_text(1'b1);
		text = '{CHAR_SPACE, CHAR_CR, CHAR_LF, "+", "/", "9"};
		send_text(1'b1);
		text = '{8'hFF, "A"};
		send_text(1'b1);
		text = '{"A"};
		send_text(1'b1);
		text = '{"Z"};
		send_text(1'b0);
		set_mode(MODE_DECODE);
		text = '{"Z", "m", "9", "v"};
		send_text(1'b1);
		wait_drained();

		// random phases alternating the mode; a phase may end mid-string
		sent  = 0;
		phase = 0;
		while (sent < ITEM_TARGET) begin
			m = phase[0] ? MODE_DECODE : MODE_ENCODE;
			set_mode(m);
			phase_end = sent + PHASE_ITEMS;
			while (sent < phase_end && sent < ITEM_TARGET) begin
				if (m == MODE_ENCODE)
					make_bytes();
				else
					make_chars();
				close = !(sent + text.size() >= phase_end && $urandom_range(0, 1) == 1);
				send_text(close);
				sent = sent + text.size();
				if ($urandom_range(0, 9) == 0)
					wait_drained();
			end
			phase = phase + 1;
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && results_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
rtl/b64c_pkg.sv
rtl/b64c_step.sv
rtl/base64_codec.sv
test/b64c_checker.sv
test/tb_base64_codec.sv
